### hw/rtl/vfur_pkg.sv
// vfur_pkg: shared types and constants for the vertex first-use renumbering block
// used by vertex_first_use_renumbering and vfur_checker; no dependencies
`default_nettype none

package vfur_pkg;

  // field widths
  localparam int unsigned IdxW = 12;
  localparam int unsigned CntW = 13;

  // map store depth, one entry per possible old index
  localparam int unsigned MapDepth = 1 << IdxW;

  // size of the old vertex list, only indices below it are mapped
  localparam int unsigned MaxVerts = 4096;

  typedef struct packed {
    logic [IdxW-1:0] vertex_index;
    logic            new_mesh;
  } in_t;

  typedef struct packed {
    logic [IdxW-1:0] remapped_index;
    logic            first_use;
    logic [IdxW-1:0] source_index;
    logic [CntW-1:0] used_count;
  } out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_BACK
  } state_e;

endpackage

`default_nettype wire

### hw/rtl/vertex_first_use_renumbering.sv
// vertex_first_use_renumbering: top level, map memories, sequencer and result register
// depends on vfur_pkg
`default_nettype none

// Renumbers a stream of old vertex indices into a dense list in order of first use.
// Each transfer in gives exactly one transfer out, carrying the new index, a first-use
// flag (copy vertex source_index into slot remapped_index) and the count of distinct
// vertices so far. new_mesh on an item starts a fresh numbering from zero. The map is
// held as a sparse set in two 4096 x 12 synchronous memories: a forward map (old index
// to new index) and a back map (new index to old index). An entry counts as assigned
// only when its new index is below the current count and the back map points at it, so
// new_mesh just zeroes the count and no memory sweep is needed. After reset the block
// runs one clearing pass that zeroes both memories; in_ready_o stays low during it.
// After that each item passes, one item at a time, through the forward map read, the
// dependent back map read, and a decide step that writes both maps and loads the result
// register. A result waiting in the output register only holds the decide step; the
// next item is still taken in.
module vertex_first_use_renumbering
  import vfur_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  // memories, no reset
  logic [IdxW-1:0] fwd_mem  [MapDepth];
  logic [IdxW-1:0] back_mem [MapDepth];

  state_e state_q, state_d;

  logic [IdxW-1:0] clr_q, clr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q;

  // registered read data of both memories
  logic [IdxW-1:0] fwd_rdata_q;
  logic [IdxW-1:0] back_rdata_q;

  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  logic            in_xfer;
  logic            fwd_re, back_re;
  logic            fwd_we, back_we;
  logic [IdxW-1:0] fwd_waddr, fwd_wdata;
  logic [IdxW-1:0] back_waddr, back_wdata;

  logic            in_range;
  logic            hit;
  logic            commit;
  logic            assign_new;

  assign in_xfer = in_valid_i && in_ready_o;

  // index inside the old vertex list
  assign in_range = (32'(idx_q) < MaxVerts);

  // sparse set membership: forward entry points below the count and back entry agrees
  assign hit = ({1'b0, fwd_rdata_q} < count_q) && (back_rdata_q == idx_q);

  // result slot free or being emptied this cycle
  assign commit = (state_q == ST_BACK) && (!out_valid_q || out_ready_i);

  assign assign_new = commit && in_range && !hit;

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    fwd_re      = 1'b0;
    back_re     = 1'b0;
    fwd_we      = 1'b0;
    back_we     = 1'b0;
    fwd_waddr   = idx_q;
    fwd_wdata   = count_q[IdxW-1:0];
    back_waddr  = count_q[IdxW-1:0];
    back_wdata  = idx_q;

    // output register drains independently
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        // zero both memories, one entry a cycle
        fwd_we     = 1'b1;
        back_we    = 1'b1;
        fwd_waddr  = clr_q;
        fwd_wdata  = '0;
        back_waddr = clr_q;
        back_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == IdxW'(MapDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_xfer) begin
          fwd_re  = 1'b1;
          state_d = ST_MAP;
          if (in_data_i.new_mesh) begin
            count_d = '0;
          end
        end
      end
      ST_MAP: begin
        // forward entry is in, look up the back map at it
        back_re = 1'b1;
        state_d = ST_BACK;
      end
      ST_BACK: begin
        if (commit) begin
          out_valid_d          = 1'b1;
          out_d.source_index   = idx_q;
          out_d.first_use      = assign_new;
          if (!in_range) begin
            out_d.remapped_index = '0;
            out_d.used_count     = count_q;
          end else if (hit) begin
            out_d.remapped_index = fwd_rdata_q;
            out_d.used_count     = count_q;
          end else begin
            out_d.remapped_index = count_q[IdxW-1:0];
            out_d.used_count     = count_q + 1'b1;
          end
          if (assign_new) begin
            fwd_we  = 1'b1;
            back_we = 1'b1;
            count_d = count_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_xfer) begin
      idx_q <= in_data_i.vertex_index;
    end
  end

  // forward map: old index to new index
  always_ff @(posedge clk_i) begin
    if (fwd_we) begin
      fwd_mem[fwd_waddr] <= fwd_wdata;
    end
    if (fwd_re) begin
      fwd_rdata_q <= fwd_mem[in_data_i.vertex_index];
    end
  end

  // back map: new index to old index
  always_ff @(posedge clk_i) begin
    if (back_we) begin
      back_mem[back_waddr] <= back_wdata;
    end
    if (back_re) begin
      back_rdata_q <= back_mem[fwd_rdata_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### hw/rtl/vfur_checker.sv
// vfur_checker: port-level assertions for vertex_first_use_renumbering, bound to the top
// depends on vfur_pkg
`default_nettype none

module vfur_checker
  import vfur_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire in_t  in_data_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  // a stalled input transfer holds
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input dropped or changed while stalled");

  // a stalled result holds
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // count never passes the number of distinct indices
  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.used_count <= CntW'(MapDepth))
    else $error("used_count beyond table size");

  // a first use gets the newest slot
  a_first_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.first_use |->
      out_data_o.used_count == {1'b0, out_data_o.remapped_index} + 1'b1)
    else $error("first use not given the next dense index");

  // a repeat maps to a slot already handed out, or to zero
  a_repeat_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.first_use |->
      ({1'b0, out_data_o.remapped_index} < out_data_o.used_count) ||
      (out_data_o.remapped_index == '0))
    else $error("repeat index maps beyond assigned range");

endmodule

bind vertex_first_use_renumbering vfur_checker u_vfur_checker (.*);

`default_nettype wire

### bench/tb_vertex_first_use_renumbering.sv
// tb_vertex_first_use_renumbering: self-checking bench for the vertex renumbering block
// random mesh streams with a built-in first-use predictor; depends on vfur_pkg and the rtl
`timescale 1ns / 100ps

module tb_vertex_first_use_renumbering;
  import vfur_pkg::*;

  logic clk_i;
  logic rst_ni = 1'b0;

  // stimulus side of the block
  logic in_valid = 1'b0;
  in_t  in_data  = '0;
  logic in_ready;

  // result side of the block
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // idle odds in percent, changed between phases
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // corners waiting to be driven, and remap results waiting to arrive
  in_t  pending_corners [$];
  out_t expected_remaps [$];
  int   queued_total = 0;
  int   mismatches = 0;

  // predictor state: which old indices have a new slot, the slot, and the slot count
  logic            slot_taken [MapDepth];
  logic [IdxW-1:0] slot_index [MapDepth];
  logic [CntW-1:0] distinct_count;

  vertex_first_use_renumbering DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // forget every assignment and restart numbering at zero
  function automatic void clear_renumbering();
    for (int i = 0; i < MapDepth; i++) begin
      slot_taken[i] = 1'b0;
      slot_index[i] = '0;
    end
    distinct_count = '0;
  endfunction

  // expected result for one corner, updating the predictor state
  function automatic out_t renumber_vertex(in_t corner);
    out_t r;
    if (corner.new_mesh) clear_renumbering();
    r = '0;
    r.source_index = corner.vertex_index;
    // indices past the vertex list are passed through unmapped
    if (corner.vertex_index < MaxVerts) begin
      if (!slot_taken[corner.vertex_index]) begin
        // first sighting takes the next dense slot
        slot_taken[corner.vertex_index] = 1'b1;
        slot_index[corner.vertex_index] = distinct_count[IdxW-1:0];
        distinct_count = distinct_count + 1'b1;
        r.first_use = 1'b1;
      end
      r.remapped_index = slot_index[corner.vertex_index];
    end
    r.used_count = distinct_count;
    return r;
  endfunction

  // driver: a new corner is offered only when the slot is free or the last one transferred,
  // so valid and data hold steady while the block stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        // transfer happened on this edge, predict its result now
        expected_remaps.insert(expected_remaps.size(), renumber_vertex(in_data));
      end
      if (!in_valid || in_ready) begin
        if (pending_corners.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_corners.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, each result transfer checked against the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_remaps.size() == 0) begin
          $error("unexpected result: remapped_index %0d source_index %0d",
                 out_data.remapped_index, out_data.source_index);
          mismatches++;
        end else begin
          out_t want;
          want = expected_remaps.pop_front();
          if (out_data.remapped_index !== want.remapped_index) begin
            $error("remapped_index: expected %0d, got %0d",
                   want.remapped_index, out_data.remapped_index);
            mismatches++;
          end
          if (out_data.first_use !== want.first_use) begin
            $error("first_use: expected %0d, got %0d", want.first_use, out_data.first_use);
            mismatches++;
          end
          if (out_data.source_index !== want.source_index) begin
            $error("source_index: expected %0d, got %0d",
                   want.source_index, out_data.source_index);
            mismatches++;
          end
          if (out_data.used_count !== want.used_count) begin
            $error("used_count: expected %0d, got %0d", want.used_count, out_data.used_count);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_corner(input logic [IdxW-1:0] idx, input logic fresh);
    in_t c;
    c.vertex_index = idx;
    c.new_mesh     = fresh;
    pending_corners.insert(pending_corners.size(), c);
    queued_total++;
  endtask

  // one mesh: new_mesh on the first corner, then corners drawn from a small vertex pool
  // so many corners hit earlier assignments; a few noise corners break the pattern
  task automatic queue_mesh();
    logic [IdxW-1:0] pool [$];
    int              pool_size;
    int              corners;
    logic [IdxW-1:0] idx;
    logic            fresh;
    pool_size = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(3, 48);
    for (int k = 0; k < pool_size; k++) begin
      case ($urandom_range(9))
        0: pool.insert(pool.size(), '0);
        1: pool.insert(pool.size(), '1);
        default: pool.insert(pool.size(), IdxW'($urandom));
      endcase
    end
    corners = $urandom_range(pool_size, 2 * pool_size);
    for (int k = 0; k < corners; k++) begin
      fresh = (k == 0);
      idx   = pool[$urandom_range(pool.size() - 1)];
      if ($urandom_range(99) < 4) begin
        // stray corner, sometimes restarting the numbering mid-mesh
        idx   = IdxW'($urandom);
        fresh = ($urandom_range(9) == 0);
      end
      queue_corner(idx, fresh);
    end
  endtask

  // a shuffled run of distinct old indices pushing the count up,
  // then repeats of them that must all hit
  task automatic queue_index_sweep();
    int order [MapDepth];
    int j;
    int tmp;
    for (int i = 0; i < MapDepth; i++) order[i] = i;
    for (int i = MapDepth - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < 160; i++) queue_corner(IdxW'(order[i]), i == 0);
    for (int i = 0; i < 40; i++) queue_corner(IdxW'(order[$urandom_range(159)]), 1'b0);
  endtask

  task automatic wait_all_sent();
    while (pending_corners.size() != 0 || in_valid) @(posedge clk_i);
  endtask

  initial begin
    int goal;
    clear_renumbering();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // phase one: light sender gaps, heavy receiver stalls
    send_idle_pct = 13;
    recv_idle_pct = 56;

    // directed corners; the first relies on the post-reset map being empty
    queue_corner(12'd0, 1'b0);     // first use after reset
    queue_corner(12'd0, 1'b0);     // hit
    queue_corner(12'd4095, 1'b0);  // top index
    queue_corner(12'd4095, 1'b0);
    queue_corner(12'd2730, 1'b0);  // alternating bit patterns
    queue_corner(12'd1365, 1'b0);
    queue_corner(12'd0, 1'b0);
    queue_corner(12'd4095, 1'b1);  // restart mid stream, old hit becomes first use
    queue_corner(12'd0, 1'b0);
    queue_corner(12'd1365, 1'b0);
    queue_corner(12'd4095, 1'b1);  // back-to-back restarts on the same index
    queue_corner(12'd4095, 1'b1);
    queue_corner(12'd4095, 1'b0);
    queue_corner(12'd7, 1'b0);     // one triangle with a shared corner
    queue_corner(12'd8, 1'b0);
    queue_corner(12'd7, 1'b0);
    queue_corner(12'd2048, 1'b1);
    queue_corner(12'd1, 1'b0);
    queue_corner(12'd2048, 1'b0);
    queue_corner(12'd0, 1'b1);     // restart on index zero
    queue_corner(12'd0, 1'b0);

    goal = queued_total + 420;
    while (queued_total < goal) queue_mesh();
    wait_all_sent();

    // phase two: sender idles often, receiver rarely
    send_idle_pct = 56;
    recv_idle_pct = 13;
    goal = queued_total + 420;
    while (queued_total < goal) queue_mesh();
    wait_all_sent();

    // phase three: back to back, including the index sweep
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_index_sweep();
    goal = queued_total + 60;
    while (queued_total < goal) queue_mesh();
    wait_all_sent();

    while (expected_remaps.size() != 0) @(posedge clk_i);
    // idle on to catch any stray result before the verdict
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the clearing pass plus the slowest stalled run
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
hw/rtl/vfur_pkg.sv
hw/rtl/vertex_first_use_renumbering.sv
hw/rtl/vfur_checker.sv
bench/tb_vertex_first_use_renumbering.sv
